// ===== design/tcu_pkg.sv =====
// Shared types, sizes and codes of the toy CPU control unit.
`timescale 1ns / 1ps

package tcu_pkg;

   // Field widths.
   localparam int ADDR_W  = 11;
   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int INSTR_W = 16;
   localparam int OPC_W   = 5;

   // Storage sizes (powers of two; an address keeps its low bits).
   localparam int MEM_DEPTH = 2048;
   localparam int IO_DEPTH  = 32;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int IO_AW     = $clog2(IO_DEPTH);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD     = 2'd0,
      MODE_STEP     = 2'd1,
      MODE_PEEK_MEM = 2'd2,
      MODE_PEEK_IO  = 2'd3
   } mode_type;

   typedef enum logic [OPC_W-1:0] {
      OP_WM  = 5'h01,
      OP_RM  = 5'h02,
      OP_BR  = 5'h03,
      OP_RIO = 5'h04,
      OP_WIO = 5'h05,
      OP_WB  = 5'h06,
      OP_WIB = 5'h07,
      OP_EOP = 5'h1F
   } opcode_type;

   typedef enum logic [5:0] {
      S_CLEAR    = 6'b000001,
      S_IDLE     = 6'b000010,
      S_FETCH_HI = 6'b000100,
      S_FETCH_LO = 6'b001000,
      S_MEM_RD   = 6'b010000,
      S_PEEK     = 6'b100000
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  prog_counter;
      logic [INSTR_W-1:0] instruction;
      logic [OPC_W-1:0]   opcode;
      logic [BYTE_W-1:0]  mem_buffer;
      logic [BYTE_W-1:0]  io_buffer_reg;
      logic               halted;
      logic [BYTE_W-1:0]  read_data;
   } tcu_result_type;

endpackage

// ===== design/tcu_rsp_buf.sv =====
// Two-entry result buffer: an output register backed by a skid register.
`timescale 1ns / 1ps

module tcu_rsp_buf
   import tcu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tcu_result_type push_data,
   output logic           skid_busy,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output tcu_result_type rsp_data
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   tcu_result_type out_ff, out_in;
   tcu_result_type skid_ff, skid_in;
   logic           pop;

   assign pop = out_valid_ff & rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // The older word moves up; a new word takes its place behind it.
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign skid_busy = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A new word may only arrive at a full skid register when the output drains.
   assert property (@(posedge clock) disable iff (reset)
      (push && skid_valid_ff) |-> pop)
      else $error("result word pushed into a full buffer");

   // The skid register never holds a word while the output register is empty.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without an output word");

endmodule

// ===== design/toy_cpu_control_unit.sv =====
// Top level of the toy CPU control unit: sequencer, data memory and I/O buffer.
`timescale 1ns / 1ps
//
// Every word on the req_ channel is one command selected by req_mode: load a
// byte into data memory, execute one instruction, peek data memory, or peek
// the I/O buffer. Each command returns exactly one word on the rsp_ channel
// showing the machine registers after the command.
// Data memory is a single-ported synchronous RAM with registered read data,
// so its port sets the pace. A step reads the high instruction byte, then the
// low byte, then decodes and executes; its result word is pushed in the
// low-byte state, after which the sequencer returns to idle for the next
// command. A read-memory opcode needs the memory-read state for its operand
// read. A memory peek returns its result from the peek state; a load, an I/O
// peek and a step after halt return theirs from the idle state.
// After reset the data memory is cleared by a pass over all 2048 bytes, one byte a
// cycle, during which req_ready stays low. The I/O buffer and the registers
// clear at once.
// Results sit in an output register backed by a skid register, so a stalled
// receiver does not stop the next command from being accepted; req_ready
// drops while both hold a word and whenever the sequencer is not idle.

module toy_cpu_control_unit
   import tcu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic [BYTE_W-1:0]  req_write_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ADDR_W-1:0]  rsp_prog_counter,
   output logic [INSTR_W-1:0] rsp_instruction,
   output logic [OPC_W-1:0]   rsp_opcode,
   output logic [BYTE_W-1:0]  rsp_mem_buffer,
   output logic [BYTE_W-1:0]  rsp_io_buffer_reg,
   output logic               rsp_halted,
   output logic [BYTE_W-1:0]  rsp_read_data
);

   localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_DEPTH - 1);

   // Architectural and sequencing registers.
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [BYTE_W-1:0]  mbr_ff, mbr_in;
   logic [BYTE_W-1:0]  iobr_ff, iobr_in;
   logic               halt_ff, halt_in;
   logic [BYTE_W-1:0]  hi_ff, hi_in;
   logic [INSTR_W-1:0] instr_ff, instr_in;
   logic [MEM_AW-1:0]  clr_cnt_ff, clr_cnt_in;

   // Data memory and its single port.
   logic [BYTE_W-1:0]  data_mem [MEM_DEPTH];
   logic [BYTE_W-1:0]  mem_rdata_ff;
   logic               mem_we;
   logic [MEM_AW-1:0]  mem_addr;
   logic [BYTE_W-1:0]  mem_wdata;

   // I/O buffer, held in flops so that reset clears it at once.
   logic [BYTE_W-1:0]  io_store_ff [IO_DEPTH];
   logic               io_we;
   logic [IO_AW-1:0]   io_idx;

   logic               req_accept;
   logic               skid_busy;
   logic               push;
   tcu_result_type     push_data;
   tcu_result_type     rsp_data;
   logic [INSTR_W-1:0] res_instr;
   logic [BYTE_W-1:0]  res_rdata;
   logic [INSTR_W-1:0] fetched;
   logic [ADDR_W-1:0]  operand;
   logic [ADDR_W-1:0]  pc_plus1;

   assign req_ready  = (state_ff == S_IDLE) && !skid_busy;
   assign req_accept = req_valid && req_ready;

   // In the low-byte cycle the RAM output holds the low byte.
   assign fetched  = {hi_ff, mem_rdata_ff};
   assign operand  = fetched[ADDR_W-1:0];
   assign pc_plus1 = pc_ff + ADDR_W'(1);

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      mbr_in     = mbr_ff;
      iobr_in    = iobr_ff;
      halt_in    = halt_ff;
      hi_in      = hi_ff;
      instr_in   = instr_ff;
      clr_cnt_in = clr_cnt_ff;
      mem_we     = 1'b0;
      mem_addr   = pc_ff[MEM_AW-1:0];
      mem_wdata  = mbr_ff;
      io_we      = 1'b0;
      io_idx     = req_address[IO_AW-1:0];
      push       = 1'b0;
      res_instr  = '0;
      res_rdata  = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     mem_we    = 1'b1;
                     mem_addr  = req_address[MEM_AW-1:0];
                     mem_wdata = req_write_data;
                     push      = 1'b1;
                  end
                  MODE_STEP: begin
                     if (halt_ff) begin
                        push = 1'b1;
                     end else begin
                        mem_addr = pc_ff[MEM_AW-1:0];
                        state_in = S_FETCH_HI;
                     end
                  end
                  MODE_PEEK_MEM: begin
                     mem_addr = req_address[MEM_AW-1:0];
                     state_in = S_PEEK;
                  end
                  MODE_PEEK_IO: begin
                     res_rdata = io_store_ff[io_idx];
                     push      = 1'b1;
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH_HI: begin
            hi_in    = mem_rdata_ff;
            pc_in    = pc_plus1;
            mem_addr = pc_plus1[MEM_AW-1:0];
            state_in = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            pc_in     = pc_plus1;
            instr_in  = fetched;
            res_instr = fetched;
            io_idx    = operand[IO_AW-1:0];
            push      = 1'b1;
            state_in  = S_IDLE;
            case (opcode_type'(fetched[INSTR_W-1:ADDR_W]))
               OP_WM: begin
                  mem_we    = 1'b1;
                  mem_addr  = operand[MEM_AW-1:0];
                  mem_wdata = mbr_ff;
               end
               OP_RM: begin
                  // The operand read goes through the memory-read state before the result.
                  mem_addr = operand[MEM_AW-1:0];
                  push     = 1'b0;
                  state_in = S_MEM_RD;
               end
               OP_BR:  pc_in   = operand;
               OP_RIO: iobr_in = io_store_ff[io_idx];
               OP_WIO: io_we   = 1'b1;
               OP_WB:  mbr_in  = fetched[BYTE_W-1:0];
               OP_WIB: iobr_in = fetched[BYTE_W-1:0];
               OP_EOP: halt_in = 1'b1;
               default: begin
               end
            endcase
         end
         S_MEM_RD: begin
            mbr_in    = mem_rdata_ff;
            res_instr = instr_ff;
            push      = 1'b1;
            state_in  = S_IDLE;
         end
         S_PEEK: begin
            res_rdata = mem_rdata_ff;
            push      = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The result word shows the registers as they stand after this command.
      push_data.prog_counter  = pc_in;
      push_data.instruction   = res_instr;
      push_data.opcode        = res_instr[INSTR_W-1:ADDR_W];
      push_data.mem_buffer    = mbr_in;
      push_data.io_buffer_reg = iobr_in;
      push_data.halted        = halt_in;
      push_data.read_data     = res_rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         pc_ff      <= '0;
         mbr_ff     <= '0;
         iobr_ff    <= '0;
         halt_ff    <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pc_ff      <= pc_in;
         mbr_ff     <= mbr_in;
         iobr_ff    <= iobr_in;
         halt_ff    <= halt_in;
         clr_cnt_ff <= clr_cnt_in;
      end
      hi_ff    <= hi_in;
      instr_ff <= instr_in;
   end

   // Single-ported data memory, read before write, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= data_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IO_DEPTH; i++) begin
            io_store_ff[i] <= '0;
         end
      end else if (io_we) begin
         io_store_ff[io_idx] <= iobr_ff;
      end
   end

   tcu_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .skid_busy (skid_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_prog_counter  = rsp_data.prog_counter;
   assign rsp_instruction   = rsp_data.instruction;
   assign rsp_opcode        = rsp_data.opcode;
   assign rsp_mem_buffer    = rsp_data.mem_buffer;
   assign rsp_io_buffer_reg = rsp_data.io_buffer_reg;
   assign rsp_halted        = rsp_data.halted;
   assign rsp_read_data     = rsp_data.read_data;

   // Once halted, the machine stays halted until reset.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(halt_ff))
      else $error("halt flag cleared without reset");

   // The program counter moves only in the high and low fetch states.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(pc_ff)) |->
         ($past(state_ff) == S_FETCH_HI || $past(state_ff) == S_FETCH_LO))
      else $error("program counter changed outside a fetch");

   // A step taken while halted leaves the program counter alone.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_STEP && halt_ff) |=> $stable(pc_ff))
      else $error("step after halt moved the program counter");

   // No command is taken while the clearing pass still owns the memory port.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("command accepted during memory clearing");

endmodule
